>>> rtl/wsp_pkg.sv
`timescale 1ns / 1ps
package wsp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W = 32;
	localparam int PAIR_W = 64;
	localparam int PROD_W = 64;
	localparam int ROW_W = 66;
	localparam int NUM_W = 67;
	localparam int SIZE_W = 16;
	localparam int MUL_W = NUM_W + SIZE_W;
	localparam int REM_W = MUL_W + 1;
	localparam int SCR_W = 16;
	localparam int DIV_STEPS = SCR_W;
	localparam int DOT_DEPTH = 3;
	localparam int LANE_DEPTH = DIV_STEPS + 4;
	localparam int PIPE_DEPTH = DOT_DEPTH + 1 + LANE_DEPTH;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	typedef enum logic [2:0] {
		REG_ROW0_FIRST = 3'd0,
		REG_ROW0_SECOND = 3'd1,
		REG_ROW1_FIRST = 3'd2,
		REG_ROW1_SECOND = 3'd3,
		REG_ROW3_FIRST = 3'd4,
		REG_ROW3_SECOND = 3'd5,
		REG_DISPLAY_SIZE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
		logic vis;
	} lane_in_t;

endpackage

>>> rtl/wsp_dot.sv
`timescale 1ns / 1ps
module wsp_dot import wsp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic en,
	input logic [PAIR_W-1:0] first,
	input logic [PAIR_W-1:0] second,
	input logic signed [WORD_W-1:0] x,
	input logic signed [WORD_W-1:0] y,
	input logic signed [WORD_W-1:0] z,
	output logic signed [ROW_W-1:0] sum_s3
);

	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [ROW_W-2:0] a_s2, b_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= $signed(first[WORD_W-1:0]) * x;
			p1_s1 <= $signed(first[PAIR_W-1:WORD_W]) * y;
			p2_s1 <= $signed(second[WORD_W-1:0]) * z;
			p3_s1 <= PROD_W'($signed(second[PAIR_W-1:WORD_W])) <<< FRAC_BITS;
			a_s2 <= {p0_s1[PROD_W-1], p0_s1} + {p1_s1[PROD_W-1], p1_s1};
			b_s2 <= {p2_s1[PROD_W-1], p2_s1} + {p3_s1[PROD_W-1], p3_s1};
			sum_s3 <= {a_s2[ROW_W-2], a_s2} + {b_s2[ROW_W-2], b_s2};
		end
	end

endmodule

>>> rtl/wsp_lane.sv
`timescale 1ns / 1ps
module wsp_lane import wsp_pkg::*; (
	input logic clk,
	input logic en,
	input lane_in_t in_s4,
	input logic [SIZE_W-1:0] size,
	output logic signed [SCR_W-1:0] res_s24
);

	logic [NUM_W-1:0] mag_s5, den_s5;
	logic neg_s5, vis_s5;
	logic [MUL_W-1:0] prod_s6;
	logic [NUM_W-1:0] den_s6;
	logic neg_s6, vis_s6;
	logic [REM_W-1:0] div_rem_s [DIV_STEPS+1];
	logic [SCR_W-1:0] div_q_s [DIV_STEPS+1];
	logic [NUM_W-1:0] div_den_s [DIV_STEPS+1];
	logic div_neg_s [DIV_STEPS+1];
	logic div_sat_s [DIV_STEPS+1];
	logic div_vis_s [DIV_STEPS+1];
	logic [REM_W-1:0] sat_lim;
	logic [SCR_W-1:0] q_up;

	assign sat_lim = REM_W'(den_s6) << (SCR_W - 1);
	assign q_up = div_q_s[DIV_STEPS] + SCR_W'(|div_rem_s[DIV_STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s5 <= in_s4.num[NUM_W-1];
			mag_s5 <= in_s4.num[NUM_W-1] ? NUM_W'(-in_s4.num) : NUM_W'(in_s4.num);
			den_s5 <= in_s4.den;
			vis_s5 <= in_s4.vis;

			prod_s6 <= MUL_W'(mag_s5) * MUL_W'(size);
			den_s6 <= den_s5;
			neg_s6 <= neg_s5;
			vis_s6 <= vis_s5;

			div_rem_s[0] <= REM_W'(prod_s6);
			div_q_s[0] <= '0;
			div_den_s[0] <= den_s6;
			div_neg_s[0] <= neg_s6;
			div_vis_s[0] <= vis_s6;
			div_sat_s[0] <= neg_s6 ? (REM_W'(prod_s6) > sat_lim)
				: (REM_W'(prod_s6) >= sat_lim);

			for (int k = 0; k < DIV_STEPS; k++) begin
				if (div_rem_s[k] >= (REM_W'(div_den_s[k]) << (DIV_STEPS - 1 - k))) begin
					div_rem_s[k+1] <= div_rem_s[k]
						- (REM_W'(div_den_s[k]) << (DIV_STEPS - 1 - k));
					div_q_s[k+1] <= {div_q_s[k][SCR_W-2:0], 1'b1};
				end else begin
					div_rem_s[k+1] <= div_rem_s[k];
					div_q_s[k+1] <= {div_q_s[k][SCR_W-2:0], 1'b0};
				end
				div_den_s[k+1] <= div_den_s[k];
				div_neg_s[k+1] <= div_neg_s[k];
				div_sat_s[k+1] <= div_sat_s[k];
				div_vis_s[k+1] <= div_vis_s[k];
			end

			if (!div_vis_s[DIV_STEPS]) begin
				res_s24 <= '0;
			end else if (!div_neg_s[DIV_STEPS]) begin
				res_s24 <= div_sat_s[DIV_STEPS] ? {1'b0, {(SCR_W-1){1'b1}}}
					: div_q_s[DIV_STEPS];
			end else begin
				res_s24 <= div_sat_s[DIV_STEPS] ? {1'b1, {(SCR_W-1){1'b0}}} : -q_up;
			end
		end
	end

endmodule

>>> rtl/world_to_screen_projection.sv
`timescale 1ns / 1ps
// world-to-screen projection of one q16.16 point per transfer
// input channel: pos_x, pos_y, pos_z with pos_valid / pos_stall
// output channel: visible, screen_x, screen_y with screen_valid / screen_stall
// matrix rows 0, 1, 3 and display size are written over the apb port;
// the user must write them only while no transfer is in flight, and the
// block itself does not enforce this
// throughput: one point per cycle when not stalled; fully pipelined:
// three multiply/sum stages, one depth stage, and per axis a magnitude,
// size multiply, saturation check, 16 one-bit divide stages and a sign fix
// reset zeroes matrix, size and valid registers and empties the pipeline
// when screen_stall holds a valid result the whole pipeline freezes and
// pos_stall rises in the same cycle; nothing is lost or repeated
module world_to_screen_projection import wsp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	input logic pos_valid,
	output logic pos_stall,
	input logic signed [WORD_W-1:0] pos_x,
	input logic signed [WORD_W-1:0] pos_y,
	input logic signed [WORD_W-1:0] pos_z,
	output logic screen_valid,
	input logic screen_stall,
	output logic visible,
	output logic signed [SCR_W-1:0] screen_x,
	output logic signed [SCR_W-1:0] screen_y
);

	localparam longint DEPTH_MIN = ((longint'(1) << FRAC_BITS) + 999) / 1000;
	localparam logic signed [ROW_W-1:0] LIMIT = ROW_W'(DEPTH_MIN) << FRAC_BITS;

	logic [PAIR_W-1:0] row0a_q, row0b_q, row1a_q, row1b_q, row3a_q, row3b_q;
	logic [WORD_W-1:0] size_q;
	logic adv;
	logic [PIPE_DEPTH-1:0] vld_s;
	logic vis_s [PIPE_DEPTH-DOT_DEPTH];
	logic signed [ROW_W-1:0] cx_s3, cy_s3, w_s3;
	lane_in_t lx_s4, ly_s4;
	reg_idx_t widx;

	assign pready = 1'b1;
	assign widx = reg_idx_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0a_q <= '0;
			row0b_q <= '0;
			row1a_q <= '0;
			row1b_q <= '0;
			row3a_q <= '0;
			row3b_q <= '0;
			size_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				REG_ROW0_FIRST: row0a_q <= pwdata;
				REG_ROW0_SECOND: row0b_q <= pwdata;
				REG_ROW1_FIRST: row1a_q <= pwdata;
				REG_ROW1_SECOND: row1b_q <= pwdata;
				REG_ROW3_FIRST: row3a_q <= pwdata;
				REG_ROW3_SECOND: row3b_q <= pwdata;
				REG_DISPLAY_SIZE: size_q <= pwdata[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_ROW0_FIRST: prdata = row0a_q;
			REG_ROW0_SECOND: prdata = row0b_q;
			REG_ROW1_FIRST: prdata = row1a_q;
			REG_ROW1_SECOND: prdata = row1b_q;
			REG_ROW3_FIRST: prdata = row3a_q;
			REG_ROW3_SECOND: prdata = row3b_q;
			REG_DISPLAY_SIZE: prdata = DATA_W'(size_q);
			default: prdata = '0;
		endcase
	end

	assign adv = !(vld_s[PIPE_DEPTH-1] && screen_stall);
	assign pos_stall = !adv;
	assign screen_valid = vld_s[PIPE_DEPTH-1];
	assign visible = vis_s[PIPE_DEPTH-DOT_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_DEPTH-2:0], pos_valid};
		end
	end

	wsp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_x (
		.clk(clk), .en(adv), .first(row0a_q), .second(row0b_q),
		.x(pos_x), .y(pos_y), .z(pos_z), .sum_s3(cx_s3)
	);
	wsp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_y (
		.clk(clk), .en(adv), .first(row1a_q), .second(row1b_q),
		.x(pos_x), .y(pos_y), .z(pos_z), .sum_s3(cy_s3)
	);
	wsp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_w (
		.clk(clk), .en(adv), .first(row3a_q), .second(row3b_q),
		.x(pos_x), .y(pos_y), .z(pos_z), .sum_s3(w_s3)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			lx_s4.num <= {w_s3[ROW_W-1], w_s3} + {cx_s3[ROW_W-1], cx_s3};
			ly_s4.num <= {w_s3[ROW_W-1], w_s3} - {cy_s3[ROW_W-1], cy_s3};
			lx_s4.den <= {w_s3, 1'b0};
			ly_s4.den <= {w_s3, 1'b0};
			lx_s4.vis <= w_s3 >= LIMIT;
			ly_s4.vis <= w_s3 >= LIMIT;
			vis_s[0] <= w_s3 >= LIMIT;
			for (int k = 1; k < PIPE_DEPTH - DOT_DEPTH; k++) begin
				vis_s[k] <= vis_s[k-1];
			end
		end
	end

	wsp_lane u_lane_x (
		.clk(clk), .en(adv), .in_s4(lx_s4), .size(size_q[SIZE_W-1:0]),
		.res_s24(screen_x)
	);
	wsp_lane u_lane_y (
		.clk(clk), .en(adv), .in_s4(ly_s4), .size(size_q[WORD_W-1:SIZE_W]),
		.res_s24(screen_y)
	);

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid && !visible |-> screen_x == '0 && screen_y == '0)
		else $error("hidden point with nonzero screen position");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!screen_valid |-> !pos_stall)
		else $error("input stalled with empty output stage");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid && screen_stall |=> screen_valid && $stable(screen_x)
		&& $stable(screen_y) && $stable(visible))
		else $error("stalled result changed");

endmodule
